>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NAT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never");
`define NAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`else
`define NAT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define NAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/nat_pkg.sv
// Types and constants of the node address table.
package nat_pkg;
    localparam int MAX_NODES_DEF = 1024;
    localparam int ADDR_BYTES_DEF = 6;
    localparam int MAX_READ_DEF = 32;
    localparam int ADDR_W = 48;
    localparam int BYTE_W = 8;
    localparam int IDX_OUT_W = 10;
    localparam int CNT_OUT_W = 11;
    localparam int START_W = 10;
    localparam int RCNT_W = 6;
    localparam int ENTRY_W = ADDR_W + 2 * BYTE_W;
    localparam logic [BYTE_W-1:0] ALL_TYPES = 8'hFF;
    localparam logic [BYTE_W-1:0] FRESH_RESULT = 8'd2;

    typedef enum logic [2:0] {
        OP_FIND = 3'd0, OP_ADD = 3'd1, OP_DELETE = 3'd2, OP_MODIFY = 3'd3,
        OP_READ = 3'd4, OP_TSLOT = 3'd5, OP_CLEAR = 3'd6, OP_NONE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DUP = 2'd1, ST_FULL = 2'd2, ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_OWN = 2'd0, CFG_NULL = 2'd1
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FIN, S_P2_RD, S_P2_EV
    } t_state;

    typedef struct packed {
        t_status                status;
        logic                   found;
        logic                   is_own;
        logic [IDX_OUT_W-1:0]   node_index;
        logic [CNT_OUT_W-1:0]   total;
        logic [CNT_OUT_W-1:0]   slot;
        logic                   entry_valid;
        logic [ADDR_W-1:0]      entry_address;
        logic [BYTE_W-1:0]      entry_type;
        logic [BYTE_W-1:0]      entry_last_result;
        logic                   last;
    } t_result;
endpackage

>>> src/nat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module nat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/node_address_table.sv
// Node address table: top level with scan sequencer and entry memory.
//
// Channels: an input channel (i_in_valid/o_in_ready) carries one operation,
// an output channel (o_out_valid/i_out_ready) returns its results, and a
// configuration channel (i_cfg_valid/o_cfg_ready) writes own_address (index
// 0) and null_address (index 1); other indexes are ignored.
// One item is worked at a time. Find, add, delete, modify, read page and
// time slot sweep the memory below the high-water mark, one read per cycle.
// Read page then sweeps again, reading and then evaluating each entry, to
// hand out up to read_count entries, the last flagged by o_last. Clear and
// the unused code skip the sweep.
// The memory port (one read per cycle) bounds the sweep rate.
// An output register holds a finished result; a new item is taken while it
// waits. When the receiver stalls, the sequencer holds on its next result.
// Reset empties the table (mark to zero) and restores the register values;
// no clearing pass is run.
module node_address_table #(
    parameter int MAX_NODES = nat_pkg::MAX_NODES_DEF,
    parameter int ADDR_BYTES = nat_pkg::ADDR_BYTES_DEF,
    parameter int MAX_READ = nat_pkg::MAX_READ_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_operation,
    input  logic [nat_pkg::ADDR_W-1:0]     i_address,
    input  logic [nat_pkg::ADDR_W-1:0]     i_new_address,
    input  logic [nat_pkg::BYTE_W-1:0]     i_node_type,
    input  logic [nat_pkg::BYTE_W-1:0]     i_type_filter,
    input  logic [nat_pkg::START_W-1:0]    i_start_index,
    input  logic [nat_pkg::RCNT_W-1:0]     i_read_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [nat_pkg::ADDR_W-1:0]     i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic                           o_found,
    output logic                           o_is_own,
    output logic [nat_pkg::IDX_OUT_W-1:0]  o_node_index,
    output logic [nat_pkg::CNT_OUT_W-1:0]  o_total,
    output logic [nat_pkg::CNT_OUT_W-1:0]  o_slot,
    output logic                           o_entry_valid,
    output logic [nat_pkg::ADDR_W-1:0]     o_entry_address,
    output logic [nat_pkg::BYTE_W-1:0]     o_entry_type,
    output logic [nat_pkg::BYTE_W-1:0]     o_entry_last_result,
    output logic                           o_last
);
`include "assert_macros.svh"

    localparam int AW = nat_pkg::ADDR_W;
    localparam int BW = nat_pkg::BYTE_W;
    localparam int EW = nat_pkg::ENTRY_W;
    localparam int IW = $clog2(MAX_NODES);
    localparam int HW = $clog2(MAX_NODES + 1);
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int CW = ((HW > nat_pkg::START_W) ? HW : nat_pkg::START_W) + 1;
    localparam logic [AW-1:0] AMASK = (ADDR_BYTES >= AW / 8) ? {AW{1'b1}} :
        AW'((64'(1) << (8 * ADDR_BYTES)) - 64'(1));

    function automatic logic f_eq(input logic [AW-1:0] a, input logic [AW-1:0] b);
        return ((a ^ b) & AMASK) == '0;
    endfunction

    nat_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_own, r_null;
    logic [HW-1:0]   r_hw, n_hw;
    // latched item
    nat_pkg::t_op    r_op, n_op;
    logic [AW-1:0]   r_addr, n_addr, r_naddr, n_naddr;
    logic [BW-1:0]   r_dtype, n_dtype, r_filt, n_filt;
    logic [nat_pkg::START_W-1:0] r_start, n_start;
    logic [RW-1:0]   r_want, n_want;
    // scan
    logic [HW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic            r_fa, n_fa, r_fn, n_fn, r_fe, n_fe;
    logic [IW-1:0]   r_ia, n_ia, r_in, n_in, r_ie, n_ie;
    logic [BW-1:0]   r_ht, n_ht, r_hr, n_hr;
    logic [HW-1:0]   r_cnt, n_cnt, r_slot, n_slot, r_total, n_total;
    logic [RW-1:0]   r_got, n_got, r_emit, n_emit;
    // output
    logic            r_out_valid, n_out_valid;
    nat_pkg::t_result r_out, n_out;
    // memory
    logic            ram_we, ram_re;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;

    logic [AW-1:0]   d_addr;
    logic [BW-1:0]   d_type, d_res;
    logic            d_empty, d_filt;
    logic            out_free;
    logic            own_a, null_a, hit_a, own_n, null_n, hit_n;
    logic [CW-1:0]   avail;

    nat_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign d_addr   = ram_rdata[EW-1 -: AW];
    assign d_type   = ram_rdata[2*BW-1 -: BW];
    assign d_res    = ram_rdata[BW-1:0];
    assign d_empty  = f_eq(d_addr, r_null);
    assign d_filt   = !d_empty && (r_filt == nat_pkg::ALL_TYPES || d_type == r_filt);
    assign out_free = !r_out_valid || i_out_ready;
    assign own_a    = f_eq(r_addr, r_own);
    assign null_a   = f_eq(r_addr, r_null);
    assign hit_a    = !own_a && !null_a && r_fa;
    assign own_n    = f_eq(r_naddr, r_own);
    assign null_n   = f_eq(r_naddr, r_null);
    assign hit_n    = !own_n && !null_n && r_fn;
    assign avail    = (CW'(r_cnt) > CW'(r_start)) ? CW'(r_cnt) - CW'(r_start) : '0;

    assign o_in_ready  = (r_state == nat_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;   n_hw = r_hw;       n_op = r_op;
        n_addr = r_addr;     n_naddr = r_naddr; n_dtype = r_dtype;
        n_filt = r_filt;     n_start = r_start; n_want = r_want;
        n_idx = r_idx;       n_pend = 1'b0;     n_pidx = r_pidx;
        n_fa = r_fa;  n_fn = r_fn;  n_fe = r_fe;
        n_ia = r_ia;  n_in = r_in;  n_ie = r_ie;
        n_ht = r_ht;  n_hr = r_hr;
        n_cnt = r_cnt; n_slot = r_slot; n_total = r_total;
        n_got = r_got; n_emit = r_emit;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out = r_out;
        ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;
        ram_re = 1'b0; ram_raddr = r_idx[IW-1:0];

        case (r_state)
            nat_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = nat_pkg::t_op'(i_operation);
                    n_addr  = i_address;
                    n_naddr = i_new_address;
                    n_dtype = i_node_type;
                    n_filt  = i_type_filter;
                    n_start = i_start_index;
                    n_want  = (7'(i_read_count) > 7'(MAX_READ)) ? RW'(MAX_READ)
                                                                 : RW'(i_read_count);
                    n_idx = '0;
                    n_fa = 1'b0; n_fn = 1'b0; n_fe = 1'b0;
                    n_ia = '0;   n_in = '0;   n_ie = '0;
                    n_cnt = '0;  n_slot = '0;
                    if (i_operation == nat_pkg::OP_CLEAR || i_operation == nat_pkg::OP_NONE) begin
                        n_state = nat_pkg::S_FIN;
                    end else begin
                        n_state = nat_pkg::S_SCAN;
                    end
                end
            end
            nat_pkg::S_SCAN: begin
                // one read issued per cycle, data evaluated in the next cycle
                if (r_idx < r_hw) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + HW'(1);
                end
                if (r_pend) begin
                    if (f_eq(d_addr, r_addr) && !r_fa) begin
                        n_fa = 1'b1; n_ia = r_pidx; n_ht = d_type; n_hr = d_res;
                    end
                    if (f_eq(d_addr, r_naddr) && !r_fn) begin
                        n_fn = 1'b1; n_in = r_pidx;
                    end
                    if (d_empty && !r_fe) begin
                        n_fe = 1'b1; n_ie = r_pidx;
                    end
                    if (r_op == nat_pkg::OP_READ && d_filt) begin
                        n_cnt = r_cnt + HW'(1);
                    end
                    if (r_op == nat_pkg::OP_TSLOT && !d_empty) begin
                        n_cnt = r_cnt + HW'(1);
                        if (f_eq(d_addr, r_addr)) begin
                            n_slot = r_cnt + HW'(1);
                        end
                    end
                end else if (r_idx >= r_hw) begin
                    n_state = nat_pkg::S_FIN;
                end
            end
            nat_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_state = nat_pkg::S_IDLE;
                    case (r_op)
                        nat_pkg::OP_FIND: begin
                            n_out.status = (own_a || hit_a) ? nat_pkg::ST_OK
                                                            : nat_pkg::ST_ABSENT;
                            n_out.found = hit_a;
                            n_out.is_own = own_a;
                            n_out.node_index = hit_a ? nat_pkg::IDX_OUT_W'(r_ia) : '0;
                        end
                        nat_pkg::OP_ADD: begin
                            if (own_a || hit_a) begin
                                n_out.status = nat_pkg::ST_DUP;
                            end else if (r_hw == HW'(MAX_NODES)) begin
                                n_out.status = nat_pkg::ST_FULL;
                            end else begin
                                n_out.status = nat_pkg::ST_OK;
                                ram_we = 1'b1;
                                ram_waddr = r_fe ? r_ie : r_hw[IW-1:0];
                                ram_wdata = {r_addr, r_dtype, nat_pkg::FRESH_RESULT};
                                n_out.node_index = nat_pkg::IDX_OUT_W'(ram_waddr);
                                if (!r_fe) begin
                                    n_hw = r_hw + HW'(1);
                                end
                            end
                        end
                        nat_pkg::OP_DELETE: begin
                            if (!hit_a) begin
                                n_out.status = nat_pkg::ST_ABSENT;
                            end else begin
                                n_out.status = nat_pkg::ST_OK;
                                n_out.node_index = nat_pkg::IDX_OUT_W'(r_ia);
                                ram_we = 1'b1;
                                ram_waddr = r_ia;
                                ram_wdata = {r_null, r_ht, r_hr};
                                if (HW'(r_ia) == r_hw - HW'(1)) begin
                                    n_hw = r_hw - HW'(1);
                                end
                            end
                        end
                        nat_pkg::OP_MODIFY: begin
                            if (!hit_a) begin
                                n_out.status = nat_pkg::ST_ABSENT;
                            end else if (own_n || (hit_n && r_in != r_ia)) begin
                                n_out.status = nat_pkg::ST_DUP;
                            end else begin
                                n_out.status = nat_pkg::ST_OK;
                                n_out.node_index = nat_pkg::IDX_OUT_W'(r_ia);
                                ram_we = 1'b1;
                                ram_waddr = r_ia;
                                ram_wdata = {r_naddr, r_dtype, r_hr};
                            end
                        end
                        nat_pkg::OP_READ: begin
                            n_total = r_cnt;
                            n_got = (avail > CW'(r_want)) ? r_want : RW'(avail);
                            if (avail == '0 || r_want == '0) begin
                                n_out.status = nat_pkg::ST_OK;
                                n_out.total = nat_pkg::CNT_OUT_W'(r_cnt);
                            end else begin
                                // second sweep hands out the page
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out = r_out;
                                n_idx = '0;
                                n_cnt = '0;
                                n_emit = '0;
                                n_state = nat_pkg::S_P2_RD;
                            end
                        end
                        nat_pkg::OP_TSLOT: begin
                            if (r_slot == '0) begin
                                n_out.status = nat_pkg::ST_ABSENT;
                            end else begin
                                n_out.status = nat_pkg::ST_OK;
                                n_out.total = nat_pkg::CNT_OUT_W'(r_cnt);
                                n_out.slot = nat_pkg::CNT_OUT_W'(r_slot);
                            end
                        end
                        nat_pkg::OP_CLEAR: begin
                            n_out.status = nat_pkg::ST_OK;
                            n_hw = '0;
                        end
                        default: begin
                            n_out.status = nat_pkg::ST_ABSENT;
                        end
                    endcase
                end
            end
            nat_pkg::S_P2_RD: begin
                ram_re = 1'b1;
                n_pidx = r_idx[IW-1:0];
                n_idx = r_idx + HW'(1);
                n_state = nat_pkg::S_P2_EV;
            end
            nat_pkg::S_P2_EV: begin
                if (!d_filt) begin
                    n_state = nat_pkg::S_P2_RD;
                end else if (CW'(r_cnt) < CW'(r_start)) begin
                    n_cnt = r_cnt + HW'(1);
                    n_state = nat_pkg::S_P2_RD;
                end else if (out_free) begin
                    // hold the read data until the output register frees
                    n_cnt = r_cnt + HW'(1);
                    n_emit = r_emit + RW'(1);
                    n_out_valid = 1'b1;
                    n_out = '0;
                    n_out.status = nat_pkg::ST_OK;
                    n_out.node_index = nat_pkg::IDX_OUT_W'(r_pidx);
                    n_out.total = nat_pkg::CNT_OUT_W'(r_total);
                    n_out.entry_valid = 1'b1;
                    n_out.entry_address = d_addr;
                    n_out.entry_type = d_type;
                    n_out.entry_last_result = d_res;
                    n_out.last = (r_emit + RW'(1) == r_got);
                    n_state = n_out.last ? nat_pkg::S_IDLE : nat_pkg::S_P2_RD;
                end
            end
            default: begin
                n_state = nat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nat_pkg::S_IDLE;
            r_hw <= '0;
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_own <= '0;
            r_null <= {AW{1'b1}};
        end else begin
            r_state <= n_state;
            r_hw <= n_hw;
            r_pend <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == nat_pkg::CFG_OWN) begin
                    r_own <= i_cfg_data;
                end else if (i_cfg_index == nat_pkg::CFG_NULL) begin
                    r_null <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;       r_addr <= n_addr;   r_naddr <= n_naddr;
        r_dtype <= n_dtype; r_filt <= n_filt;   r_start <= n_start;
        r_want <= n_want;   r_idx <= n_idx;     r_pidx <= n_pidx;
        r_fa <= n_fa;  r_fn <= n_fn;  r_fe <= n_fe;
        r_ia <= n_ia;  r_in <= n_in;  r_ie <= n_ie;
        r_ht <= n_ht;  r_hr <= n_hr;
        r_cnt <= n_cnt; r_slot <= n_slot; r_total <= n_total;
        r_got <= n_got; r_emit <= n_emit;
        r_out <= n_out;
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out.status;
    assign o_found             = r_out.found;
    assign o_is_own            = r_out.is_own;
    assign o_node_index        = r_out.node_index;
    assign o_total             = r_out.total;
    assign o_slot              = r_out.slot;
    assign o_entry_valid       = r_out.entry_valid;
    assign o_entry_address     = r_out.entry_address;
    assign o_entry_type        = r_out.entry_type;
    assign o_entry_last_result = r_out.entry_last_result;
    assign o_last              = r_out.last;

    `NAT_ASSERT_NEVER(a_hw_bound, i_clk, i_rst_n, r_hw > HW'(MAX_NODES))
    `NAT_ASSERT_IMPL(a_pend_scan, i_clk, i_rst_n, r_pend, r_state == nat_pkg::S_SCAN)
    `NAT_ASSERT_IMPL(a_write_fin, i_clk, i_rst_n, ram_we, r_state == nat_pkg::S_FIN && out_free)
    `NAT_ASSERT_IMPL(a_emit_bound, i_clk, i_rst_n, r_state == nat_pkg::S_P2_EV, r_emit < r_got)
endmodule

>>> tb/nat_monitor.sv
// Checker for the node address table: tracks the table and compares each output transfer.
module nat_monitor
    import nat_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [2:0]             i_operation,
    input  logic [ADDR_W-1:0]      i_address,
    input  logic [ADDR_W-1:0]      i_new_address,
    input  logic [BYTE_W-1:0]      i_node_type,
    input  logic [BYTE_W-1:0]      i_type_filter,
    input  logic [START_W-1:0]     i_start_index,
    input  logic [RCNT_W-1:0]      i_read_count,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [ADDR_W-1:0]      i_cfg_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_result                i_result,
    output int                     o_mismatches,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {MISS, OWN_HIT, TABLE_HIT} t_hit;

    logic [ADDR_W-1:0] addr_mem [MAX_NODES_DEF];
    logic [BYTE_W-1:0] type_mem [MAX_NODES_DEF];
    logic [BYTE_W-1:0] res_mem  [MAX_NODES_DEF];
    int                mark;
    logic [ADDR_W-1:0] own_addr;
    logic [ADDR_W-1:0] null_addr;
    t_result           expected_results [$];
    int                mismatches;

    assign o_mismatches = mismatches;
    assign o_pending = expected_results.size();

    initial begin
        mismatches = 0;
        mark = 0;
        foreach (addr_mem[i]) begin
            addr_mem[i] = '0;
            type_mem[i] = '0;
            res_mem[i] = '0;
        end
    end

    function automatic t_hit locate(input logic [ADDR_W-1:0] a, output int idx);
        idx = 0;
        if (a == own_addr) return OWN_HIT;
        if (a == null_addr) return MISS;
        for (int i = 0; i < mark; i++) begin
            if (addr_mem[i] == a) begin
                idx = i;
                return TABLE_HIT;
            end
        end
        return MISS;
    endfunction

    function automatic void push_result(t_status st, logic fnd, logic own, int idx,
                                        int total, int slot, logic ev,
                                        logic [ADDR_W-1:0] ea, logic [BYTE_W-1:0] et,
                                        logic [BYTE_W-1:0] er, logic lst);
        t_result r;
        r.status = st;
        r.found = fnd;
        r.is_own = own;
        r.node_index = idx[IDX_OUT_W-1:0];
        r.total = total[CNT_OUT_W-1:0];
        r.slot = slot[CNT_OUT_W-1:0];
        r.entry_valid = ev;
        r.entry_address = ea;
        r.entry_type = et;
        r.entry_last_result = er;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    // Apply one operation to the table copy and queue what it must return.
    function automatic void apply_operation();
        int   idx, nidx, want, total, slot, i;
        t_hit hit, nhit;
        int   picks [$];

        want = (i_read_count > MAX_READ_DEF) ? MAX_READ_DEF : i_read_count;
        case (t_op'(i_operation))
            OP_FIND: begin
                hit = locate(i_address, idx);
                push_result(hit == MISS ? ST_ABSENT : ST_OK, hit == TABLE_HIT,
                            hit == OWN_HIT, idx, 0, 0, 0, '0, '0, '0, 1);
            end
            OP_ADD: begin
                hit = locate(i_address, idx);
                if (hit != MISS) begin
                    push_result(ST_DUP, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
                end else if (mark >= MAX_NODES_DEF) begin
                    push_result(ST_FULL, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
                end else begin
                    for (i = 0; i < mark; i++)
                        if (addr_mem[i] == null_addr) break;
                    if (i >= mark) mark = mark + 1;
                    addr_mem[i] = i_address;
                    type_mem[i] = i_node_type;
                    res_mem[i] = FRESH_RESULT;
                    push_result(ST_OK, 0, 0, i, 0, 0, 0, '0, '0, '0, 1);
                end
            end
            OP_DELETE: begin
                hit = locate(i_address, idx);
                if (hit != TABLE_HIT) begin
                    push_result(ST_ABSENT, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
                end else begin
                    if (mark > 0 && idx == mark - 1) mark--;
                    addr_mem[idx] = null_addr;
                    push_result(ST_OK, 0, 0, idx, 0, 0, 0, '0, '0, '0, 1);
                end
            end
            OP_MODIFY: begin
                hit = locate(i_address, idx);
                if (hit != TABLE_HIT) begin
                    push_result(ST_ABSENT, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
                end else begin
                    nhit = locate(i_new_address, nidx);
                    if (nhit == OWN_HIT || (nhit == TABLE_HIT && nidx != idx)) begin
                        push_result(ST_DUP, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
                    end else begin
                        addr_mem[idx] = i_new_address;
                        type_mem[idx] = i_node_type;
                        push_result(ST_OK, 0, 0, idx, 0, 0, 0, '0, '0, '0, 1);
                    end
                end
            end
            OP_READ: begin
                total = 0;
                for (i = 0; i < mark; i++) begin
                    if (addr_mem[i] == null_addr) continue;
                    if (i_type_filter == ALL_TYPES || type_mem[i] == i_type_filter) begin
                        if (total >= i_start_index && picks.size() < want)
                            picks.push_back(i);
                        total++;
                    end
                end
                if (picks.size() == 0)
                    push_result(ST_OK, 0, 0, 0, total, 0, 0, '0, '0, '0, 1);
                foreach (picks[k])
                    push_result(ST_OK, 0, 0, picks[k], total, 0, 1, addr_mem[picks[k]],
                                type_mem[picks[k]], res_mem[picks[k]],
                                k == picks.size() - 1);
            end
            OP_TSLOT: begin
                total = 0;
                slot = 0;
                for (i = 0; i < mark; i++) begin
                    if (addr_mem[i] == null_addr) continue;
                    total++;
                    if (addr_mem[i] == i_address) slot = total;
                end
                if (slot == 0) total = 0;
                push_result(slot != 0 ? ST_OK : ST_ABSENT, 0, 0, 0, total, slot,
                            0, '0, '0, '0, 1);
            end
            OP_CLEAR: begin
                mark = 0;
                push_result(ST_OK, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
            end
            default: push_result(ST_ABSENT, 0, 0, 0, 0, 0, 0, '0, '0, '0, 1);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        logic    bad;
        if (!i_rst_n) begin
            mark = 0;
            own_addr = '0;
            null_addr = '1;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg'(i_cfg_index))
                    CFG_OWN:  own_addr = i_cfg_data;
                    CFG_NULL: null_addr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected output transfer %p", $time, i_result);
                end else begin
                    e = expected_results.pop_front();
                    bad = (i_result.status !== e.status) || (i_result.found !== e.found)
                        || (i_result.is_own !== e.is_own)
                        || (i_result.node_index !== e.node_index)
                        || (i_result.total !== e.total) || (i_result.slot !== e.slot)
                        || (i_result.entry_valid !== e.entry_valid)
                        || (i_result.entry_address !== e.entry_address)
                        || (i_result.entry_type !== e.entry_type)
                        || (i_result.entry_last_result !== e.entry_last_result)
                        || (i_result.last !== e.last);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $time, e, i_result);
                    end
                end
            end
            if (i_in_valid && i_in_ready) apply_operation();
        end
    end
endmodule

>>> tb/testbench.sv
// Top of the node address table testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nat_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid, in_ready;
    logic [2:0]            operation;
    logic [ADDR_W-1:0]     address, new_address;
    logic [BYTE_W-1:0]     node_type, type_filter;
    logic [START_W-1:0]    start_index;
    logic [RCNT_W-1:0]     read_count;
    logic                  cfg_valid, cfg_ready;
    logic [1:0]            cfg_index;
    logic [ADDR_W-1:0]     cfg_data;
    logic                  out_valid, out_ready;
    logic [1:0]            out_status;
    t_result               result;
    int                    mismatches, pending;

    bit                    no_idle;
    int                    holds_asked, holds_done, stall_left;
    logic [ADDR_W-1:0]     own_val, null_val;
    logic [ADDR_W-1:0]     pool [6];

    node_address_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_operation(operation), .i_address(address), .i_new_address(new_address),
        .i_node_type(node_type), .i_type_filter(type_filter),
        .i_start_index(start_index), .i_read_count(read_count),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(out_status), .o_found(result.found), .o_is_own(result.is_own),
        .o_node_index(result.node_index), .o_total(result.total), .o_slot(result.slot),
        .o_entry_valid(result.entry_valid), .o_entry_address(result.entry_address),
        .o_entry_type(result.entry_type),
        .o_entry_last_result(result.entry_last_result), .o_last(result.last)
    );

    assign result.status = t_status'(out_status);

    nat_monitor monitor (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_operation(operation), .i_address(address), .i_new_address(new_address),
        .i_node_type(node_type), .i_type_filter(type_filter),
        .i_start_index(start_index), .i_read_count(read_count),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_result(result),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge i_clk) begin
        int r;
        if (holds_asked != holds_done) begin
            holds_done++;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            r = $urandom_range(0, 9);
            if (no_idle || r < 7) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                stall_left = (r == 9) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            end
        end
    end

    task automatic send(t_op op, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] na = '0,
                        logic [BYTE_W-1:0] dt = '0, logic [BYTE_W-1:0] tf = ALL_TYPES,
                        logic [START_W-1:0] si = '0, logic [RCNT_W-1:0] rc = '0);
        int r, gap;
        operation <= op;
        address <= a;
        new_address <= na;
        node_type <= dt;
        type_filter <= tf;
        start_index <= si;
        read_count <= rc;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        r = $urandom_range(0, 9);
        gap = no_idle || r < 6 ? 0 : (r < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg idx, logic [ADDR_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN) own_val = data;
        else null_val = data;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 15);
        if (r < 12) return pool[$urandom_range(0, 5)];
        if (r == 12) return own_val;
        if (r == 13) return null_val;
        return ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic random_item();
        int        r;
        t_op       op;
        logic [BYTE_W-1:0] dt, tf;
        r = $urandom_range(0, 99);
        op = r < 30 ? OP_ADD : r < 45 ? OP_FIND : r < 58 ? OP_DELETE : r < 70 ? OP_MODIFY :
             r < 82 ? OP_READ : r < 94 ? OP_TSLOT : r < 97 ? OP_CLEAR : OP_NONE;
        dt = $urandom_range(0, 4) == 0 ? BYTE_W'($urandom) : BYTE_W'($urandom_range(0, 3));
        r = $urandom_range(0, 3);
        tf = r == 0 ? ALL_TYPES : r == 1 ? BYTE_W'($urandom) : BYTE_W'($urandom_range(0, 3));
        send(op, pick_address(), pick_address(), dt, tf,
             $urandom_range(0, 5) == 0 ? START_W'($urandom) : START_W'($urandom_range(0, 3)),
             RCNT_W'($urandom));
    endtask

    localparam logic [ADDR_W-1:0] ADDR_A = 48'h0123_4567_89AB;
    localparam logic [ADDR_W-1:0] ADDR_B = 48'hFEDC_BA98_7654;
    localparam logic [ADDR_W-1:0] ADDR_C = 48'hA5A5_5A5A_0F0F;

    initial begin
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        out_ready = 1'b0;
        operation = '0;
        address = '0;
        new_address = '0;
        node_type = '0;
        type_filter = '0;
        start_index = '0;
        read_count = '0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        holds_asked = 0;
        holds_done = 0;
        stall_left = 0;
        own_val = '0;
        null_val = '1;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Special cases with the reset register values.
        send(OP_READ, '0, '0, '0, ALL_TYPES, '0, 6'd63);
        send(OP_TSLOT, ADDR_A);
        send(OP_ADD, ADDR_A, '0, 8'h55);
        send(OP_ADD, ADDR_B, '0, 8'hAA);
        send(OP_ADD, '0);
        send(OP_ADD, ADDR_A);
        send(OP_ADD, '1, '0, 8'h0F);
        send(OP_FIND, '0);
        send(OP_FIND, '1);
        send(OP_FIND, ADDR_B);
        send(OP_FIND, ADDR_C);
        send(OP_DELETE, ADDR_C);
        send(OP_DELETE, '0);
        send(OP_DELETE, ADDR_A);
        send(OP_ADD, ADDR_C, '0, 8'hF0);
        send(OP_MODIFY, '0, ADDR_A);
        send(OP_MODIFY, ADDR_C, '0);
        send(OP_MODIFY, ADDR_C, ADDR_B);
        send(OP_MODIFY, ADDR_C, ADDR_C, 8'h0F);
        send(OP_MODIFY, ADDR_B, '1);
        send(OP_READ, '0, '0, '0, ALL_TYPES, '0, 6'd63);
        send(OP_READ, '0, '0, '0, 8'h0F, '0, 6'd1);
        send(OP_TSLOT, ADDR_C);
        send(OP_NONE, ADDR_C);
        send(OP_CLEAR, '0);

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(CFG_OWN, '1);
                    write_reg(CFG_NULL, '0);
                end
                1: begin
                    write_reg(CFG_OWN, ADDR_W'({$urandom, $urandom}));
                    write_reg(CFG_NULL, ADDR_W'({$urandom, $urandom}));
                end
                default: begin
                    write_reg(CFG_NULL, '1);
                    write_reg(CFG_OWN, '0);
                end
            endcase
            foreach (pool[i]) pool[i] = ADDR_W'({$urandom, $urandom});
            for (int n = 0; n < 35; n++) begin
                no_idle = (n < 10);
                // Stall the receiver long enough for the input side to back up.
                if (ph == 1 && n == 15) holds_asked++;
                random_item();
            end
            no_idle = 1'b0;
        end

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
